>>> rtl/fpvp_pkg.sv
// Shared types, codes, constants and control store for the flash page vector patcher.
package fpvp_pkg;

  localparam int unsigned PAGE_BYTES_DEF = 64;

  localparam logic [15:0] JUMP_OPCODE = 16'hC000;
  localparam logic [15:0] ERASE_WORD  = 16'hFFFF;

  // register indexes on the configuration port
  localparam logic [2:0] REG_BOOT_ADDRESS = 3'd0;
  localparam logic [2:0] REG_RESET_VEC    = 3'd1;
  localparam logic [2:0] REG_USB_VEC      = 3'd2;
  localparam logic [2:0] REG_TINY_RESET   = 3'd3;
  localparam logic [2:0] REG_TINY_USB     = 3'd4;
  localparam logic [2:0] REG_FLASH_BYTES  = 3'd5;

  localparam logic [15:0] BOOT_ADDRESS_RST = 16'd6144;
  localparam logic [4:0]  RESET_VEC_RST    = 5'd0;
  localparam logic [4:0]  USB_VEC_RST      = 5'd1;
  localparam logic [7:0]  TINY_RESET_RST   = 8'd4;
  localparam logic [7:0]  TINY_USB_RST     = 8'd2;
  localparam logic [16:0] FLASH_BYTES_RST  = 17'd8192;

  typedef enum logic [1:0] {
    REQ_SET_ADDR = 2'd0,
    REQ_PROGRAM  = 2'd1,
    REQ_ERASE    = 2'd2
  } req_e;

  typedef enum logic [1:0] {
    CMD_FILL  = 2'd0,
    CMD_WRITE = 2'd1,
    CMD_ERASE = 2'd2,
    CMD_DROP  = 2'd3
  } cmd_e;

  typedef enum logic [1:0] {
    WP_HOLD  = 2'd0,
    WP_ADV   = 2'd1,
    WP_CLEAR = 2'd2
  } wp_op_e;

  typedef enum logic [1:0] {
    CNT_HOLD  = 2'd0,
    CNT_CLEAR = 2'd1,
    CNT_INC   = 2'd2
  } cnt_op_e;

  typedef enum logic [1:0] {
    LM_NO         = 2'd0,
    LM_YES        = 2'd1,
    LM_IF_NO_PAGE = 2'd2
  } last_mode_e;

  typedef enum logic [1:0] {
    JC_NEXT     = 2'd0,
    JC_ALWAYS   = 2'd1,
    JC_NO_PAGE  = 2'd2,
    JC_CNT_MORE = 2'd3
  } jmp_e;

  // control store addresses
  localparam int unsigned STEP_W = 3;
  localparam logic [STEP_W-1:0] ST_IDLE     = 3'd0;
  localparam logic [STEP_W-1:0] ST_PW_FILL  = 3'd1;
  localparam logic [STEP_W-1:0] ST_PW_PAGE  = 3'd2;
  localparam logic [STEP_W-1:0] ST_ER_ERASE = 3'd3;
  localparam logic [STEP_W-1:0] ST_ER_FILL  = 3'd4;
  localparam logic [STEP_W-1:0] ST_ER_PAGE  = 3'd5;

  typedef struct packed {
    logic              wait_req;  // park here until a request is taken
    logic              emit;      // step produces one result
    cmd_e              cmd;
    logic              may_drop;  // fill turns into a drop at or above the boot address
    wp_op_e            wp_op;
    cnt_op_e           cnt_op;
    last_mode_e        last_mode;
    jmp_e              jmp;
    logic [STEP_W-1:0] target;
  } uop_t;

  typedef struct packed {
    uop_t uop;
    logic go;
  } ctl_t;

  typedef struct packed {
    logic in_fire;
    req_e req;
    logic out_free;
    logic page;
    logic cnt_last;
  } seq_stat_t;

  localparam uop_t UOP_NOP = '{
    wait_req:  1'b0,
    emit:      1'b0,
    cmd:       CMD_FILL,
    may_drop:  1'b0,
    wp_op:     WP_HOLD,
    cnt_op:    CNT_HOLD,
    last_mode: LM_NO,
    jmp:       JC_NEXT,
    target:    ST_IDLE
  };

  function automatic uop_t rom_word(input logic [STEP_W-1:0] step);
    uop_t u;
    u = UOP_NOP;
    unique case (step)
      ST_IDLE: begin
        u.wait_req = 1'b1;
      end
      ST_PW_FILL: begin
        u.emit      = 1'b1;
        u.cmd       = CMD_FILL;
        u.may_drop  = 1'b1;
        u.wp_op     = WP_ADV;
        u.last_mode = LM_IF_NO_PAGE;
        u.jmp       = JC_NO_PAGE;
        u.target    = ST_IDLE;
      end
      ST_PW_PAGE: begin
        u.emit      = 1'b1;
        u.cmd       = CMD_WRITE;
        u.last_mode = LM_YES;
        u.jmp       = JC_ALWAYS;
        u.target    = ST_IDLE;
      end
      ST_ER_ERASE: begin
        u.emit   = 1'b1;
        u.cmd    = CMD_ERASE;
        u.wp_op  = WP_CLEAR;
        u.cnt_op = CNT_CLEAR;
      end
      ST_ER_FILL: begin
        u.emit   = 1'b1;
        u.cmd    = CMD_FILL;
        u.wp_op  = WP_ADV;
        u.cnt_op = CNT_INC;
        u.jmp    = JC_CNT_MORE;
        u.target = ST_ER_FILL;
      end
      ST_ER_PAGE: begin
        u.emit      = 1'b1;
        u.cmd       = CMD_WRITE;
        u.last_mode = LM_YES;
        u.jmp       = JC_ALWAYS;
        u.target    = ST_IDLE;
      end
      default: begin
        u.jmp    = JC_ALWAYS;
        u.target = ST_IDLE;
      end
    endcase
    return u;
  endfunction

endpackage

>>> rtl/fpvp_if.sv
// Request and result channel interfaces of the flash page vector patcher.
interface fpvp_in_if;
  logic        valid;
  logic        ready;
  logic [1:0]  req_type;
  logic [15:0] start_address;
  logic [15:0] data_word;
  logic        chunk_end;

  modport source (output valid, req_type, start_address, data_word, chunk_end, input ready);
  modport sink   (input valid, req_type, start_address, data_word, chunk_end, output ready);
endinterface

interface fpvp_out_if;
  logic        valid;
  logic        ready;
  logic [1:0]  cmd;
  logic [15:0] cmd_address;
  logic [15:0] cmd_data;
  logic        clear_buffer;
  logic        last;

  modport source (output valid, cmd, cmd_address, cmd_data, clear_buffer, last, input ready);
  modport sink   (input valid, cmd, cmd_address, cmd_data, clear_buffer, last, output ready);
endinterface

>>> rtl/flash_page_vector_patcher_unit.sv
// Flash page vector patcher: top level with config registers and datapath.
//
// Requests arrive on in_if (valid/ready): set address, program word or erase.
// Results leave on out_if (valid/ready) through one output register, so a
// finished result may wait there while the next request is taken.
// A set-address request gives no result. A program word is accepted, then
// filled or dropped, with a page write after it when the chunk ends a page.
// An erase gives an erase command, PAGE_BYTES/2 fills and a page write.
// Each step is one word of the control store in fpvp_pkg, read by fpvp_seq,
// and emits at most one result; the single output register sets the pace.
// PAGE_BYTES must be a power of two.
// When the receiver stalls, the sequencer holds on its current step and the
// result register keeps its contents; no request is taken until the
// sequencer is back at its idle step.
// Reset (rst_ni low, asynchronous) loads the register defaults, clears the
// write pointer and saved vectors and empties the output register.
// The user must write configuration through the APB port only while the block is idle; the block does not enforce it.
module flash_page_vector_patcher_unit
  import fpvp_pkg::*;
#(
  parameter int unsigned PAGE_BYTES = PAGE_BYTES_DEF
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  fpvp_in_if.sink     in_if,
  fpvp_out_if.source  out_if,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [4:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);

  localparam int unsigned PB_W  = $clog2(PAGE_BYTES);
  localparam int unsigned CNT_W = $clog2(PAGE_BYTES / 2);
  localparam logic [CNT_W-1:0] CNT_LAST = CNT_W'(PAGE_BYTES / 2 - 1);

  // configuration registers
  logic [15:0] boot_q;
  logic [4:0]  rst_vec_q;
  logic [4:0]  usb_vec_q;
  logic [7:0]  tiny_rst_off_q;
  logic [7:0]  tiny_usb_off_q;
  logic [16:0] flash_q;
  logic        cfg_wr;
  logic [2:0]  cfg_idx;

  assign pready  = 1'b1;
  assign cfg_idx = paddr[4:2];
  assign cfg_wr  = psel & penable & pwrite;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      boot_q         <= BOOT_ADDRESS_RST;
      rst_vec_q      <= RESET_VEC_RST;
      usb_vec_q      <= USB_VEC_RST;
      tiny_rst_off_q <= TINY_RESET_RST;
      tiny_usb_off_q <= TINY_USB_RST;
      flash_q        <= FLASH_BYTES_RST;
    end else if (cfg_wr) begin
      case (cfg_idx)
        REG_BOOT_ADDRESS: boot_q         <= pwdata[15:0];
        REG_RESET_VEC:    rst_vec_q      <= pwdata[4:0];
        REG_USB_VEC:      usb_vec_q      <= pwdata[4:0];
        REG_TINY_RESET:   tiny_rst_off_q <= pwdata[7:0];
        REG_TINY_USB:     tiny_usb_off_q <= pwdata[7:0];
        REG_FLASH_BYTES:  flash_q        <= pwdata[16:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (cfg_idx)
      REG_BOOT_ADDRESS: prdata = {16'd0, boot_q};
      REG_RESET_VEC:    prdata = {27'd0, rst_vec_q};
      REG_USB_VEC:      prdata = {27'd0, usb_vec_q};
      REG_TINY_RESET:   prdata = {24'd0, tiny_rst_off_q};
      REG_TINY_USB:     prdata = {24'd0, tiny_usb_off_q};
      REG_FLASH_BYTES:  prdata = {15'd0, flash_q};
      default:          prdata = 32'd0;
    endcase
  end

  // values derived from configuration, registered to keep the fill path short
  logic [16:0] span;
  logic [15:0] reloc_dist;
  logic [15:0] jump_word_q, tiny_rst_addr_q, tiny_usb_addr_q, rst_bias_q, usb_bias_q;
  logic [15:0] rst_slot, usb_slot;

  assign span       = flash_q - {1'b0, boot_q};
  assign reloc_dist = span[16:1];
  assign rst_slot   = {10'd0, rst_vec_q, 1'b0};
  assign usb_slot   = {10'd0, usb_vec_q, 1'b0};

  always_ff @(posedge clk_i) begin
    jump_word_q     <= JUMP_OPCODE + {1'b0, boot_q[15:1]} - 16'd1;
    tiny_rst_addr_q <= boot_q - {8'd0, tiny_rst_off_q};
    tiny_usb_addr_q <= boot_q - {8'd0, tiny_usb_off_q};
    rst_bias_q      <= reloc_dist + 16'd2 + {11'd0, rst_vec_q};
    usb_bias_q      <= reloc_dist + 16'd1 + {11'd0, usb_vec_q};
  end

  // sequencer
  seq_stat_t stat;
  ctl_t      ctl;
  uop_t      uop;
  logic      in_fire;
  logic      out_free;
  logic      out_valid_q;
  req_e      req;

  logic [15:0]      wp_q;
  logic [15:0]      saved_rst_q, saved_usb_q;
  logic [15:0]      data_q;
  logic             drop_q, page_q;
  logic [CNT_W-1:0] cnt_q;

  assign req          = req_e'(in_if.req_type);
  assign uop          = ctl.uop;
  assign in_if.ready  = uop.wait_req;
  assign in_fire      = in_if.valid & in_if.ready;
  assign out_free     = ~out_valid_q | out_if.ready;

  assign stat = '{in_fire: in_fire, req: req, out_free: out_free,
                  page: page_q, cnt_last: (cnt_q == CNT_LAST)};

  fpvp_seq u_seq (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .stat_i (stat),
    .ctl_o  (ctl)
  );

  // request decode at accept: vector capture, drop and page-boundary check
  logic [15:0] wp_plus2;
  logic        drop_now;
  logic [15:0] wp_after;

  assign wp_plus2 = wp_q + 16'd2;
  assign drop_now = (wp_q >= boot_q);
  assign wp_after = drop_now ? wp_q : wp_plus2;

  // patched fill word at the current pointer
  logic [15:0] patch_data;

  always_comb begin
    patch_data = data_q;
    if (wp_q == rst_slot || wp_q == usb_slot) patch_data = jump_word_q;
    if (wp_q == tiny_rst_addr_q) patch_data = saved_rst_q + rst_bias_q;
    if (wp_q == tiny_usb_addr_q) patch_data = saved_usb_q + usb_bias_q;
  end

  logic step_emit, is_drop;
  cmd_e res_cmd;

  assign step_emit = ctl.go & uop.emit;
  assign is_drop   = uop.may_drop & drop_q;
  assign res_cmd   = is_drop ? CMD_DROP : uop.cmd;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wp_q        <= 16'd0;
      saved_rst_q <= 16'd0;
      saved_usb_q <= 16'd0;
      cnt_q       <= '0;
    end else begin
      if (in_fire) begin
        if (req == REQ_SET_ADDR) wp_q <= in_if.start_address;
        if (req == REQ_PROGRAM) begin
          if (wp_q == rst_slot) saved_rst_q <= in_if.data_word;
          if (wp_q == usb_slot) saved_usb_q <= in_if.data_word;
        end
      end
      if (ctl.go) begin
        unique case (uop.wp_op)
          WP_HOLD:  ;
          WP_ADV:   if (!is_drop) wp_q <= wp_plus2;
          WP_CLEAR: wp_q <= 16'd0;
          default:  ;
        endcase
        unique case (uop.cnt_op)
          CNT_HOLD:  ;
          CNT_CLEAR: cnt_q <= '0;
          CNT_INC:   cnt_q <= cnt_q + 1'b1;
          default:   ;
        endcase
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_fire) begin
      data_q <= (req == REQ_ERASE) ? ERASE_WORD : in_if.data_word;
      drop_q <= drop_now;
      page_q <= in_if.chunk_end & (wp_after[PB_W-1:0] == '0);
    end
  end

  // result register
  logic [1:0]  res_cmd_q;
  logic [15:0] res_addr_q, res_data_q;
  logic        res_clear_q, res_last_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (step_emit) begin
      out_valid_q <= 1'b1;
    end else if (out_if.ready) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (step_emit) begin
      res_cmd_q   <= res_cmd;
      res_clear_q <= (res_cmd == CMD_FILL) & (wp_q == 16'd0);
      unique case (res_cmd)
        CMD_FILL: begin
          res_addr_q <= wp_q;
          res_data_q <= patch_data;
        end
        CMD_DROP: begin
          res_addr_q <= wp_q;
          res_data_q <= data_q;
        end
        CMD_WRITE: begin
          res_addr_q <= wp_q - 16'd2;
          res_data_q <= 16'd0;
        end
        default: begin
          res_addr_q <= 16'd0;
          res_data_q <= 16'd0;
        end
      endcase
      unique case (uop.last_mode)
        LM_YES:        res_last_q <= 1'b1;
        LM_IF_NO_PAGE: res_last_q <= ~page_q;
        default:       res_last_q <= 1'b0;
      endcase
    end
  end

  assign out_if.valid        = out_valid_q;
  assign out_if.cmd          = res_cmd_q;
  assign out_if.cmd_address  = res_addr_q;
  assign out_if.cmd_data     = res_data_q;
  assign out_if.clear_buffer = res_clear_q;
  assign out_if.last         = res_last_q;

`ifndef SYNTHESIS
  // the erase step may wait on a stalled result, so check the step itself
  a_erase_first: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_fire && req == REQ_ERASE |=> uop.emit && uop.cmd == CMD_ERASE)
    else $error("erase request did not start with an erase command");

  a_write_is_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q && res_cmd_q == CMD_WRITE |-> res_last_q)
    else $error("page write not flagged as last result");

  a_clear_on_fill: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q && res_clear_q |-> res_cmd_q == CMD_FILL && res_addr_q == 16'd0)
    else $error("buffer clear outside a fill at address zero");

  a_no_take_while_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_fire |-> !step_emit)
    else $error("request taken while a result step runs");
`endif

endmodule

>>> rtl/fpvp_seq.sv
// Microcode sequencer: step counter, control store and jump logic.
module fpvp_seq
  import fpvp_pkg::*;
(
  input  logic      clk_i,
  input  logic      rst_ni,
  input  seq_stat_t stat_i,
  output ctl_t      ctl_o
);

  logic [STEP_W-1:0] step_q, step_d;
  uop_t              uop;
  logic              go;

  assign uop = rom_word(step_q);

  always_comb begin
    step_d = step_q;
    go     = 1'b0;
    if (uop.wait_req) begin
      go = stat_i.in_fire;
      if (stat_i.in_fire) begin
        case (stat_i.req)
          REQ_PROGRAM: step_d = ST_PW_FILL;
          REQ_ERASE:   step_d = ST_ER_ERASE;
          default:     step_d = step_q;
        endcase
      end
    end else if (!uop.emit || stat_i.out_free) begin
      go = 1'b1;
      unique case (uop.jmp)
        JC_NEXT:     step_d = step_q + 1'b1;
        JC_ALWAYS:   step_d = uop.target;
        JC_NO_PAGE:  step_d = stat_i.page ? step_q + 1'b1 : uop.target;
        JC_CNT_MORE: step_d = stat_i.cnt_last ? step_q + 1'b1 : uop.target;
        default:     step_d = ST_IDLE;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      step_q <= ST_IDLE;
    end else begin
      step_q <= step_d;
    end
  end

  assign ctl_o = '{uop: uop, go: go};

endmodule

>>> sim/flash_page_vector_patcher_unit_tb.sv
// Self-checking bench for the flash page patcher: queued requests, predicted command stream.
module flash_page_vector_patcher_unit_tb;
  import fpvp_pkg::*;

  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned PAGE_BYTES    = PAGE_BYTES_DEF;
  localparam int unsigned SETTLE_CYCLES = PAGE_BYTES / 2 + 8;
  localparam logic [1:0]  REQ_UNUSED    = 2'd3;

  typedef struct packed {
    logic [1:0]  req_type;
    logic [15:0] start_address;
    logic [15:0] data_word;
    logic        chunk_end;
    logic        hold;       // wait for every pending command before sending
  } flash_req_t;

  typedef struct packed {
    cmd_e        cmd;
    logic [15:0] addr;
    logic [15:0] data;
    logic        clr;
    logic        last;
  } flash_cmd_t;

  logic        clk_i = 1'b0;
  logic        rst_ni;
  logic        psel;
  logic        penable;
  logic        pwrite;
  logic [4:0]  paddr;
  logic [31:0] pwdata;
  logic [31:0] prdata;
  logic        pready;

  fpvp_in_if  req_if ();
  fpvp_out_if cmd_if ();

  flash_page_vector_patcher_unit #(
    .PAGE_BYTES(PAGE_BYTES)
  ) i_dut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .in_if  (req_if),
    .out_if (cmd_if),
    .psel   (psel),
    .penable(penable),
    .pwrite (pwrite),
    .paddr  (paddr),
    .pwdata (pwdata),
    .prdata (prdata),
    .pready (pready)
  );

  always #1 clk_i = ~clk_i;

  // shadow of the block's configuration and state
  logic [15:0] cfg_boot     = BOOT_ADDRESS_RST;
  logic [4:0]  cfg_rst_idx  = RESET_VEC_RST;
  logic [4:0]  cfg_usb_idx  = USB_VEC_RST;
  logic [7:0]  cfg_tiny_rst = TINY_RESET_RST;
  logic [7:0]  cfg_tiny_usb = TINY_USB_RST;
  logic [16:0] cfg_flash    = FLASH_BYTES_RST;
  logic [15:0] wr_ptr        = 16'd0;
  logic [15:0] saved_rst_vec = 16'd0;
  logic [15:0] saved_usb_vec = 16'd0;

  flash_req_t req_q[$];
  flash_cmd_t exp_cmd_q[$];
  flash_req_t cur_req;
  flash_cmd_t got_cmd;
  flash_cmd_t want_cmd;

  logic in_taken = 1'b0;
  logic calm     = 1'b0;
  int   in_gap   = 0;
  int   out_gap  = 0;
  int   errors   = 0;

  function automatic logic [15:0] vec_slot(input logic [4:0] idx);
    return {10'd0, idx, 1'b0};
  endfunction

  // one patched fill at the write pointer; advances the pointer
  function automatic flash_cmd_t patched_fill(input logic [15:0] word);
    logic [15:0] p;
    logic [15:0] d;
    logic [16:0] span;
    logic [15:0] reloc_dist;
    p          = wr_ptr;
    d          = word;
    span       = cfg_flash - {1'b0, cfg_boot};
    reloc_dist = span[16:1];
    if (p == vec_slot(cfg_rst_idx) || p == vec_slot(cfg_usb_idx))
      d = JUMP_OPCODE + (cfg_boot >> 1) - 16'd1;
    if (p == cfg_boot - {8'd0, cfg_tiny_rst})
      d = saved_rst_vec + reloc_dist + 16'd2 + {11'd0, cfg_rst_idx};
    if (p == cfg_boot - {8'd0, cfg_tiny_usb})
      d = saved_usb_vec + reloc_dist + 16'd1 + {11'd0, cfg_usb_idx};
    wr_ptr = p + 16'd2;
    return '{CMD_FILL, p, d, (p == 16'd0), 1'b0};
  endfunction

  task automatic predict_commands(input flash_req_t r);
    flash_cmd_t batch[$];
    case (r.req_type)
      REQ_SET_ADDR: wr_ptr = r.start_address;
      REQ_PROGRAM: begin
        if (wr_ptr == vec_slot(cfg_rst_idx)) saved_rst_vec = r.data_word;
        if (wr_ptr == vec_slot(cfg_usb_idx)) saved_usb_vec = r.data_word;
        if (wr_ptr >= cfg_boot)
          batch.push_back('{CMD_DROP, wr_ptr, r.data_word, 1'b0, 1'b0});
        else
          batch.push_back(patched_fill(r.data_word));
        if (r.chunk_end && (wr_ptr % PAGE_BYTES) == 0)
          batch.push_back('{CMD_WRITE, wr_ptr - 16'd2, 16'd0, 1'b0, 1'b0});
      end
      REQ_ERASE: begin
        wr_ptr = 16'd0;
        batch.push_back('{CMD_ERASE, 16'd0, 16'd0, 1'b0, 1'b0});
        for (int i = 0; i < PAGE_BYTES / 2; i++)
          batch.push_back(patched_fill(ERASE_WORD));
        batch.push_back('{CMD_WRITE, wr_ptr - 16'd2, 16'd0, 1'b0, 1'b0});
      end
      default: ;
    endcase
    if (batch.size() != 0) batch[batch.size() - 1].last = 1'b1;
    foreach (batch[i]) exp_cmd_q.push_back(batch[i]);
  endtask

  // request driver
  always @(negedge clk_i) begin
    if (rst_ni && (in_taken || !req_if.valid)) begin
      if (in_gap != 0) begin
        in_gap       <= in_gap - 1;
        req_if.valid <= 1'b0;
      end else if (!calm && $urandom_range(0, 7) == 0) begin
        in_gap       <= $urandom_range(0, 8);
        req_if.valid <= 1'b0;
      end else if (req_q.size() != 0 && (!req_q[0].hold || exp_cmd_q.size() == 0)) begin
        cur_req              = req_q.pop_front();
        req_if.valid         <= 1'b1;
        req_if.req_type      <= cur_req.req_type;
        req_if.start_address <= cur_req.start_address;
        req_if.data_word     <= cur_req.data_word;
        req_if.chunk_end     <= cur_req.chunk_end;
      end else begin
        req_if.valid <= 1'b0;
      end
    end
  end

  // command sink backpressure
  always @(negedge clk_i) begin
    if (out_gap != 0) begin
      out_gap      <= out_gap - 1;
      cmd_if.ready <= 1'b0;
    end else if (!calm && $urandom_range(0, 5) == 0) begin
      out_gap      <= $urandom_range(0, 8);
      cmd_if.ready <= 1'b0;
    end else begin
      cmd_if.ready <= 1'b1;
    end
  end

  // monitor: predict on accepted requests, check accepted commands
  always @(posedge clk_i) begin
    in_taken <= req_if.valid && req_if.ready;
    if (rst_ni && req_if.valid && req_if.ready)
      predict_commands('{req_if.req_type, req_if.start_address, req_if.data_word,
                         req_if.chunk_end, 1'b0});
    if (rst_ni && cmd_if.valid && cmd_if.ready) begin
      got_cmd = '{cmd_e'(cmd_if.cmd), cmd_if.cmd_address, cmd_if.cmd_data,
                  cmd_if.clear_buffer, cmd_if.last};
      if (exp_cmd_q.size() == 0) begin
        $display("%0t unexpected command: expected none,",
                 " actual cmd=%0d addr=%h data=%h clr=%b last=%b",
                 $time, got_cmd.cmd, got_cmd.addr, got_cmd.data, got_cmd.clr, got_cmd.last);
        errors++;
      end else begin
        want_cmd = exp_cmd_q.pop_front();
        if (got_cmd !== want_cmd) begin
          $display("%0t mismatch: expected cmd=%0d addr=%h data=%h clr=%b last=%b,",
                   $time, want_cmd.cmd, want_cmd.addr, want_cmd.data, want_cmd.clr,
                   want_cmd.last,
                   " actual cmd=%0d addr=%h data=%h clr=%b last=%b",
                   got_cmd.cmd, got_cmd.addr, got_cmd.data, got_cmd.clr, got_cmd.last);
          errors++;
        end
      end
    end
  end

  task automatic queue_request(input logic [1:0] t, input logic [15:0] a, input logic [15:0] d,
                               input logic ce, input logic hold);
    req_q.push_back('{t, a, d, ce, hold});
  endtask

  task automatic set_reg(input logic [2:0] idx, input logic [31:0] value);
    @(negedge clk_i);
    psel    = 1'b1;
    penable = 1'b0;
    pwrite  = 1'b1;
    paddr   = {idx, 2'b00};
    pwdata  = value;
    @(negedge clk_i);
    penable = 1'b1;
    @(negedge clk_i);
    psel    = 1'b0;
    penable = 1'b0;
    pwrite  = 1'b0;
    case (idx)
      REG_BOOT_ADDRESS: cfg_boot     = value[15:0];
      REG_RESET_VEC:    cfg_rst_idx  = value[4:0];
      REG_USB_VEC:      cfg_usb_idx  = value[4:0];
      REG_TINY_RESET:   cfg_tiny_rst = value[7:0];
      REG_TINY_USB:     cfg_tiny_usb = value[7:0];
      REG_FLASH_BYTES:  cfg_flash    = value[16:0];
      default: ;
    endcase
  endtask

  task automatic random_setting();
    logic [15:0] boot;
    boot = 16'($urandom_range(1, 1023)) << 6;
    if ($urandom_range(0, 4) == 0) boot = 16'($urandom);
    set_reg(REG_BOOT_ADDRESS, 32'(boot));
    set_reg(REG_RESET_VEC, $urandom_range(0, 31));
    set_reg(REG_USB_VEC, $urandom_range(0, 31));
    set_reg(REG_TINY_RESET, 2 * $urandom_range(1, 8));
    set_reg(REG_TINY_USB, 2 * $urandom_range(1, 8));
    set_reg(REG_FLASH_BYTES, $urandom_range(32'(boot), 65536));
  endtask

  // mostly set-address plus a chunk of words, some erases and noise
  task automatic queue_random(input int count);
    int          n;
    int          len;
    logic [1:0]  t;
    logic [15:0] base;
    n = 0;
    while (n < count) begin
      if ($urandom_range(0, 99) < 6) begin
        queue_request(REQ_ERASE, 16'($urandom), 16'($urandom), 1'($urandom), 1'b0);
        n++;
      end else if ($urandom_range(0, 99) < 10) begin
        t = 2'($urandom);
        queue_request(t, 16'($urandom), 16'($urandom), 1'($urandom), 1'b0);
        if (t != REQ_UNUSED) n++;
      end else begin
        case ($urandom_range(0, 3))
          0:       base = 16'd0;
          1:       base = (cfg_boot - 16'd64) & 16'hFFC0;
          2:       base = 16'($urandom) & 16'hFFC0;
          default: base = cfg_boot & 16'hFFC0;
        endcase
        len = ($urandom_range(0, 2) == 0) ? PAGE_BYTES / 2 : $urandom_range(1, 10);
        queue_request(REQ_SET_ADDR, base, 16'($urandom), 1'($urandom), 1'b0);
        n++;
        for (int i = 1; i <= len; i++) begin
          queue_request(REQ_PROGRAM, 16'($urandom), 16'($urandom),
                        (i == len) || ($urandom_range(0, 9) == 0), 1'b0);
          n++;
        end
      end
    end
  endtask

  // sampled at the rising edge, where the queues cannot change under us
  task automatic wait_idle();
    while (req_q.size() != 0 || req_if.valid || exp_cmd_q.size() != 0) @(posedge clk_i);
    repeat (SETTLE_CYCLES) @(posedge clk_i);
  endtask

  initial begin
    rst_ni               = 1'b0;
    psel                 = 1'b0;
    penable              = 1'b0;
    pwrite               = 1'b0;
    paddr                = '0;
    pwdata               = '0;
    req_if.valid         = 1'b0;
    req_if.req_type      = REQ_SET_ADDR;
    req_if.start_address = '0;
    req_if.data_word     = '0;
    req_if.chunk_end     = 1'b0;
    cmd_if.ready         = 1'b0;
    repeat (12) @(negedge clk_i);
    rst_ni = 1'b1;

    // default settings: vector capture, tiny slots, drops, page writes
    queue_request(REQ_SET_ADDR, 16'h0000, 16'h0000, 1'b0, 1'b0);
    queue_request(REQ_PROGRAM,  16'h0000, 16'h1234, 1'b0, 1'b0);
    queue_request(REQ_PROGRAM,  16'h0000, 16'hABCD, 1'b0, 1'b0);
    queue_request(REQ_PROGRAM,  16'h0000, 16'h0000, 1'b1, 1'b0);
    queue_request(REQ_PROGRAM,  16'hFFFF, 16'hFFFF, 1'b0, 1'b0);
    queue_request(REQ_SET_ADDR, 16'd6140, 16'hFFFF, 1'b1, 1'b0);
    queue_request(REQ_PROGRAM,  16'h0000, 16'h5555, 1'b0, 1'b0);
    queue_request(REQ_PROGRAM,  16'h0000, 16'hAAAA, 1'b1, 1'b0);
    queue_request(REQ_PROGRAM,  16'h0000, 16'h7777, 1'b1, 1'b0);
    queue_request(REQ_SET_ADDR, 16'hFFFE, 16'h0000, 1'b0, 1'b0);
    queue_request(REQ_PROGRAM,  16'h0000, 16'h8001, 1'b0, 1'b0);
    queue_request(REQ_UNUSED,   16'hFFFF, 16'hFFFF, 1'b1, 1'b0);
    queue_request(REQ_ERASE,    16'hFFFF, 16'hFFFF, 1'b1, 1'b1);
    queue_request(REQ_SET_ADDR, 16'h003E, 16'h0000, 1'b0, 1'b0);
    queue_request(REQ_PROGRAM,  16'h0000, 16'h0F0F, 1'b1, 1'b0);
    queue_request(REQ_SET_ADDR, 16'hFFFF, 16'h0000, 1'b0, 1'b0);
    queue_request(REQ_PROGRAM,  16'h0000, 16'h00FF, 1'b1, 1'b0);
    wait_idle();
    queue_random(60);
    wait_idle();

    // top extremes: unaligned boot at the end of the space, pointer wrap
    set_reg(REG_BOOT_ADDRESS, 32'h0000_FFFF);
    set_reg(REG_RESET_VEC, 32'd31);
    set_reg(REG_USB_VEC, 32'd31);
    set_reg(REG_TINY_RESET, 32'd255);
    set_reg(REG_TINY_USB, 32'd0);
    set_reg(REG_FLASH_BYTES, 32'd65536);
    queue_request(REQ_SET_ADDR, 16'd62,   16'h0000, 1'b0, 1'b0);
    queue_request(REQ_PROGRAM,  16'h0000, 16'h4321, 1'b0, 1'b0);
    queue_request(REQ_SET_ADDR, 16'hFF00, 16'h0000, 1'b0, 1'b0);
    queue_request(REQ_PROGRAM,  16'h0000, 16'h0001, 1'b0, 1'b0);
    queue_request(REQ_SET_ADDR, 16'hFFFE, 16'h0000, 1'b0, 1'b0);
    queue_request(REQ_PROGRAM,  16'h0000, 16'hFFFF, 1'b1, 1'b0);
    queue_request(REQ_ERASE,    16'h0000, 16'h0000, 1'b0, 1'b0);
    queue_random(60);
    wait_idle();

    // bottom extremes: every program word is dropped
    set_reg(REG_BOOT_ADDRESS, 32'd0);
    set_reg(REG_RESET_VEC, 32'd0);
    set_reg(REG_USB_VEC, 32'd0);
    set_reg(REG_TINY_RESET, 32'd0);
    set_reg(REG_TINY_USB, 32'd0);
    set_reg(REG_FLASH_BYTES, 32'd0);
    queue_request(REQ_SET_ADDR, 16'h0000, 16'h0000, 1'b0, 1'b0);
    queue_request(REQ_PROGRAM,  16'h0000, 16'h9999, 1'b1, 1'b0);
    queue_request(REQ_ERASE,    16'h0000, 16'h0000, 1'b0, 1'b0);
    queue_random(40);
    wait_idle();

    random_setting();
    queue_random(70);
    wait_idle();

    // last stretch runs without idling on either side
    random_setting();
    calm = 1'b1;
    queue_random(60);
    wait_idle();

    if (errors == 0 && exp_cmd_q.size() == 0) begin
      $display("flash_page_vector_patcher_unit verification clean");
    end else begin
      $display("flash_page_vector_patcher_unit verification failed");
    end
    $finish;
  end

  initial begin
    #2_000_000;
    $display("flash_page_vector_patcher_unit verification failed");
    $finish;
  end

endmodule

>>> filelist.f
rtl/fpvp_pkg.sv
rtl/fpvp_if.sv
rtl/fpvp_seq.sv
rtl/flash_page_vector_patcher_unit.sv
sim/flash_page_vector_patcher_unit_tb.sv
